FILE: rtl/rps_pkg.sv
// ----------------------------------------------------------------------------
// rps_pkg
// Types and constants shared by the reflow profile sequencer modules.
// ----------------------------------------------------------------------------
package rps_pkg;

    localparam int TEMP_W     = 10;
    localparam int DUR_W      = 20;
    localparam int STEP_W     = 16;
    localparam int SP_W       = 18;
    localparam int READ_W     = 14;
    localparam int WHOLE_W    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int FRAC_W     = 8;

    localparam logic [TEMP_W-1:0] PREHEAT_TARGET_RST = TEMP_W'(125);
    localparam logic [TEMP_W-1:0] SOAK_TARGET_RST    = TEMP_W'(180);
    localparam logic [TEMP_W-1:0] RAMPUP_TARGET_RST  = TEMP_W'(225);
    localparam logic [TEMP_W-1:0] COOL_TARGET_RST    = TEMP_W'(35);
    localparam logic [DUR_W-1:0]  SOAK_DUR_RST       = DUR_W'(120000);
    localparam logic [DUR_W-1:0]  PEAK_DUR_RST       = DUR_W'(5000);
    localparam logic [STEP_W-1:0] SOAK_STEP_RST      = STEP_W'(59);
    localparam logic [SP_W-1:0]   SP_MAX             = {SP_W{1'b1}};
    localparam logic [DUR_W-1:0]  TIMER_LAST         = DUR_W'(1);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PREHEAT = 3'd1,
        PH_SOAK    = 3'd2,
        PH_RAMPUP  = 3'd3,
        PH_PEAK    = 3'd4,
        PH_COOL    = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        ST_NONE        = 3'd0,
        ST_TRANSITION  = 3'd1,
        ST_REFUSED_HOT = 3'd2,
        ST_REFUSED_SNS = 3'd3,
        ST_ABORTED_SNS = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        MODE_SAMPLE  = 2'd0,
        MODE_START   = 2'd1,
        MODE_STOP    = 2'd2,
        MODE_MS_TICK = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PREHEAT_TARGET = 3'd0,
        CFG_SOAK_TARGET    = 3'd1,
        CFG_RAMPUP_TARGET  = 3'd2,
        CFG_COOL_TARGET    = 3'd3,
        CFG_SOAK_DUR       = 3'd4,
        CFG_PEAK_DUR       = 3'd5,
        CFG_SOAK_STEP      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [TEMP_W-1:0] preheat_target;
        logic [TEMP_W-1:0] soak_target;
        logic [TEMP_W-1:0] rampup_target;
        logic [TEMP_W-1:0] cool_target;
        logic [DUR_W-1:0]  soak_duration_ms;
        logic [DUR_W-1:0]  peak_duration_ms;
        logic [STEP_W-1:0] soak_step_q8;
    } t_cfg;

endpackage

FILE: rtl/rps_cfg_regs.sv
// ----------------------------------------------------------------------------
// rps_cfg_regs
// Profile configuration register file with direct write port.
// ----------------------------------------------------------------------------
module rps_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rps_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rps_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output rps_pkg::t_cfg                     o_cfg
);
    import rps_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PREHEAT_TARGET: n_cfg.preheat_target   = i_cfg_data[TEMP_W-1:0];
                CFG_SOAK_TARGET:    n_cfg.soak_target      = i_cfg_data[TEMP_W-1:0];
                CFG_RAMPUP_TARGET:  n_cfg.rampup_target    = i_cfg_data[TEMP_W-1:0];
                CFG_COOL_TARGET:    n_cfg.cool_target      = i_cfg_data[TEMP_W-1:0];
                CFG_SOAK_DUR:       n_cfg.soak_duration_ms = i_cfg_data[DUR_W-1:0];
                CFG_PEAK_DUR:       n_cfg.peak_duration_ms = i_cfg_data[DUR_W-1:0];
                CFG_SOAK_STEP:      n_cfg.soak_step_q8     = i_cfg_data[STEP_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.preheat_target   <= PREHEAT_TARGET_RST;
            r_cfg.soak_target      <= SOAK_TARGET_RST;
            r_cfg.rampup_target    <= RAMPUP_TARGET_RST;
            r_cfg.cool_target      <= COOL_TARGET_RST;
            r_cfg.soak_duration_ms <= SOAK_DUR_RST;
            r_cfg.peak_duration_ms <= PEAK_DUR_RST;
            r_cfg.soak_step_q8     <= SOAK_STEP_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/reflow_profile_sequencer.sv
// ----------------------------------------------------------------------------
// reflow_profile_sequencer
// Reflow profile phase sequencer: events and ticks in, phase/setpoint out.
// ----------------------------------------------------------------------------
// Result beat is registered: it appears in the cycle after the input beat is accepted.
// Throughput: one beat per cycle while i_out_ready takes the result beat; phase state updates in the accept cycle.
// The result register frees in the cycle the result beat is taken.
// Reset: phase idle, setpoint 0, timer disarmed, registers at defaults.
// ----------------------------------------------------------------------------
module reflow_profile_sequencer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rps_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rps_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_mode,
    input  logic signed [rps_pkg::READ_W-1:0]   i_temperature,
    input  logic                                i_reading_valid,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [2:0]                          o_phase,
    output logic [rps_pkg::SP_W-1:0]            o_setpoint_q8,
    output logic                                o_heater_enable,
    output logic [2:0]                          o_status
);
    import rps_pkg::*;

    t_cfg cfg;

    rps_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    t_phase            r_phase, n_phase;
    logic [SP_W-1:0]   r_setpoint, n_setpoint;
    logic [DUR_W-1:0]  r_timer, n_timer;
    logic              r_armed, n_armed;
    t_status           n_status;

    logic              r_out_valid;
    t_phase            r_out_phase;
    logic [SP_W-1:0]   r_out_setpoint;
    t_status           r_out_status;

    logic                       accept;
    logic signed [WHOLE_W-1:0]  whole;
    logic                       whole_nonneg;
    logic [WHOLE_W-2:0]         whole_mag;
    logic [TEMP_W-1:0]          target;
    logic                       temp_phase;
    logic                       hit_target;
    logic                       too_hot;
    logic                       running;
    logic [SP_W:0]              sp_sum;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        // truncate toward zero
        if (i_temperature[READ_W-1]) begin
            whole = WHOLE_W'((i_temperature + READ_W'(3)) >>> 2);
        end else begin
            whole = WHOLE_W'(i_temperature >>> 2);
        end
        whole_nonneg = !whole[WHOLE_W-1];
        whole_mag    = whole[WHOLE_W-2:0];
    end

    always_comb begin
        temp_phase = 1'b1;
        unique case (r_phase)
            PH_PREHEAT: target = cfg.preheat_target;
            PH_RAMPUP:  target = cfg.rampup_target;
            PH_COOL:    target = cfg.cool_target;
            default: begin
                target     = cfg.cool_target;
                temp_phase = 1'b0;
            end
        endcase
        hit_target = whole_nonneg && (whole_mag == (WHOLE_W-1)'(target));
        too_hot    = whole_nonneg && (whole_mag > (WHOLE_W-1)'(cfg.cool_target));
        running    = (r_phase != PH_IDLE);
        sp_sum     = (SP_W+1)'(r_setpoint) + (SP_W+1)'(cfg.soak_step_q8);
    end

    always_comb begin
        n_phase    = r_phase;
        n_setpoint = r_setpoint;
        n_timer    = r_timer;
        n_armed    = r_armed;
        n_status   = ST_NONE;
        unique case (t_mode'(i_mode))
            MODE_SAMPLE: begin
                if (running && !i_reading_valid) begin
                    n_phase  = PH_IDLE;
                    n_timer  = '0;
                    n_armed  = 1'b0;
                    n_status = ST_ABORTED_SNS;
                end else if (running && temp_phase) begin
                    if (hit_target) begin
                        n_status = ST_TRANSITION;
                        priority case (r_phase)
                            PH_PREHEAT: begin
                                n_phase = PH_SOAK;
                                n_timer = cfg.soak_duration_ms;
                                n_armed = 1'b1;
                            end
                            PH_RAMPUP: begin
                                n_phase = PH_PEAK;
                                n_timer = cfg.peak_duration_ms;
                                n_armed = 1'b1;
                            end
                            default: begin
                                n_phase = PH_IDLE;
                                n_timer = '0;
                                n_armed = 1'b0;
                            end
                        endcase
                    end
                end else if (r_phase == PH_SOAK) begin
                    n_setpoint = sp_sum[SP_W] ? SP_MAX : sp_sum[SP_W-1:0];
                end
            end
            MODE_START: begin
                if (!running) begin
                    if (!i_reading_valid) begin
                        n_status = ST_REFUSED_SNS;
                    end else if (too_hot) begin
                        n_status = ST_REFUSED_HOT;
                    end else begin
                        n_phase    = PH_PREHEAT;
                        n_setpoint = {cfg.preheat_target, FRAC_W'(0)};
                        n_status   = ST_TRANSITION;
                    end
                end
            end
            MODE_STOP: begin
                if (running) begin
                    n_phase  = PH_IDLE;
                    n_timer  = '0;
                    n_armed  = 1'b0;
                    n_status = ST_TRANSITION;
                end
            end
            MODE_MS_TICK: begin
                if (r_armed) begin
                    if (r_timer <= TIMER_LAST) begin
                        n_timer = '0;
                        n_armed = 1'b0;
                        if (r_phase == PH_SOAK) begin
                            n_phase    = PH_RAMPUP;
                            n_setpoint = {cfg.rampup_target, FRAC_W'(0)};
                            n_status   = ST_TRANSITION;
                        end else if (r_phase == PH_PEAK) begin
                            n_phase    = PH_COOL;
                            n_setpoint = {cfg.cool_target, FRAC_W'(0)};
                            n_status   = ST_TRANSITION;
                        end
                    end else begin
                        n_timer = r_timer - TIMER_LAST;
                    end
                end
            end
            default: n_status = ST_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_setpoint  <= '0;
            r_timer     <= '0;
            r_armed     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase    <= n_phase;
                r_setpoint <= n_setpoint;
                r_timer    <= n_timer;
                r_armed    <= n_armed;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_phase    <= n_phase;
            r_out_setpoint <= n_setpoint;
            r_out_status   <= n_status;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_phase         = r_out_phase;
    assign o_setpoint_q8   = r_out_setpoint;
    assign o_heater_enable = (r_out_phase != PH_IDLE);
    assign o_status        = r_out_status;

endmodule
